// ===== src/ffan_pkg.sv =====
package ffan_pkg;

	// Field widths
	localparam int REF_W = 21;
	localparam int IDX_W = 20;
	localparam int CNT_REG_W = 21;
	localparam int CFG_IDX_W = 2;

	// Record counts above this act as this
	localparam logic [CNT_REG_W-1:0] COUNT_CAP = CNT_REG_W'(1 << IDX_W);

	// Fan limit per face
	localparam int MAX_CORNERS = 16;
	localparam int CORNER_CNT_W = $clog2(MAX_CORNERS + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXCOORD_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_COUNT = 2'd2;

	// Vertex slot within a fan triangle
	localparam logic [1:0] VTX_FIRST = 2'd0;
	localparam logic [1:0] VTX_PREV = 2'd1;
	localparam logic [1:0] VTX_CUR = 2'd2;

	typedef struct packed {
		logic [REF_W-1:0] normal;
		logic [REF_W-1:0] texcoord;
		logic [REF_W-1:0] position;
	} corner_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic present;
		logic ok;
	} ref_res_t;

endpackage

// ===== src/ffan_resolve.sv =====
module ffan_resolve (
	input  logic [ffan_pkg::REF_W-1:0]     ref_val,
	input  logic [ffan_pkg::CNT_REG_W-1:0] count,
	input  logic                           optional_ref,
	output ffan_pkg::ref_res_t             res
);
	import ffan_pkg::*;

	logic             is_zero;
	logic             is_pos;
	logic             absent;
	logic [REF_W:0]   idx_pos;
	logic [REF_W:0]   idx_neg;
	logic [REF_W:0]   idx;
	logic             in_range;

	// Positive refs are one-based; others count back from the record count
	always_comb begin
		is_zero = (ref_val == '0);
		is_pos = !ref_val[REF_W-1] && !is_zero;
		absent = optional_ref && is_zero;
		idx_pos = {1'b0, ref_val} - (REF_W+1)'(1);
		idx_neg = {1'b0, count} + {ref_val[REF_W-1], ref_val};
		idx = is_pos ? idx_pos : idx_neg;
		in_range = !absent && !idx[REF_W] && (idx < {1'b0, count});
		res.present = !absent;
		res.ok = in_range;
		res.index = in_range ? idx[IDX_W-1:0] : '0;
	end

endmodule

// ===== src/face_fan_triangulator.sv =====
// A fan triangle's vertices pass from the triangle buffer through the output register.
// Throughput: one vertex per cycle while the output is not stalled; a corner that closes a triangle
// waits for a free triangle buffer, since a single resolve path feeds the output register.
// Corners that emit nothing are taken every cycle, even while a triangle drains.
// Reset clears the record counts, the corner count and all valid flags.
module face_fan_triangulator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [ffan_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ffan_pkg::CNT_REG_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ffan_pkg::REF_W-1:0]         position_ref,
	input  logic [ffan_pkg::REF_W-1:0]         texcoord_ref,
	input  logic [ffan_pkg::REF_W-1:0]         normal_ref,
	input  logic                               face_end,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ffan_pkg::IDX_W-1:0]         position_index,
	output logic                               position_ok,
	output logic [ffan_pkg::IDX_W-1:0]         texcoord_index,
	output logic                               texcoord_present,
	output logic                               texcoord_ok,
	output logic [ffan_pkg::IDX_W-1:0]         normal_index,
	output logic                               normal_present,
	output logic                               normal_ok,
	output logic                               triangle_last
);
	import ffan_pkg::*;

	logic [CNT_REG_W-1:0]    position_cnt_q;
	logic [CNT_REG_W-1:0]    texcoord_cnt_q;
	logic [CNT_REG_W-1:0]    normal_cnt_q;
	logic [CNT_REG_W-1:0]    cfg_clamped;

	corner_t                 in_corner;
	corner_t                 first_corner_q;
	corner_t                 prev_corner_q;
	logic [CORNER_CNT_W-1:0] corner_cnt_q;
	logic                    below_max;
	logic                    emits;
	logic                    in_fire;

	corner_t                 tri_first_s1;
	corner_t                 tri_prev_s1;
	corner_t                 tri_cur_s1;
	logic                    tri_valid_s1;
	logic [1:0]              vtx_sel_s1;
	logic                    s1_move;
	logic                    s1_done;
	corner_t                 vtx_corner;

	ref_res_t                pos_res;
	ref_res_t                tex_res;
	ref_res_t                nrm_res;
	logic                    out_valid_q;

	// Clamp count writes to the record cap
	assign cfg_clamped = (cfg_data > COUNT_CAP) ? COUNT_CAP : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_cnt_q <= '0;
			texcoord_cnt_q <= '0;
			normal_cnt_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_POSITION_COUNT: position_cnt_q <= cfg_clamped;
				CFG_TEXCOORD_COUNT: texcoord_cnt_q <= cfg_clamped;
				CFG_NORMAL_COUNT:   normal_cnt_q <= cfg_clamped;
				default:            ;
			endcase
		end
	end

	// Request acceptance: a corner that emits must wait for a free triangle buffer
	assign in_corner = '{normal: normal_ref, texcoord: texcoord_ref, position: position_ref};
	assign below_max = corner_cnt_q < CORNER_CNT_W'(MAX_CORNERS);
	assign emits = below_max && (corner_cnt_q >= CORNER_CNT_W'(2));
	assign s1_move = tri_valid_s1 && (!out_valid_q || out_ready);
	assign s1_done = s1_move && (vtx_sel_s1 == VTX_CUR);
	assign in_ready = !tri_valid_s1 || s1_done || !emits;
	assign in_fire = in_valid && in_ready;

	// Track first and previous corner of the face
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_cnt_q <= '0;
			first_corner_q <= '0;
			prev_corner_q <= '0;
		end else if (in_fire) begin
			if (below_max) begin
				if (corner_cnt_q == '0) begin
					first_corner_q <= in_corner;
				end
				prev_corner_q <= in_corner;
			end
			if (face_end) begin
				corner_cnt_q <= '0;
			end else if (below_max) begin
				corner_cnt_q <= corner_cnt_q + CORNER_CNT_W'(1);
			end
		end
	end

	// Triangle buffer control: load on an emitting request, drop after the third vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_valid_s1 <= 1'b0;
			vtx_sel_s1 <= VTX_FIRST;
		end else if (in_fire && emits) begin
			tri_valid_s1 <= 1'b1;
			vtx_sel_s1 <= VTX_FIRST;
		end else if (s1_done) begin
			tri_valid_s1 <= 1'b0;
			vtx_sel_s1 <= VTX_FIRST;
		end else if (s1_move) begin
			vtx_sel_s1 <= vtx_sel_s1 + 2'd1;
		end
	end

	// Triangle buffer payload
	always_ff @(posedge clk) begin
		if (in_fire && emits) begin
			tri_first_s1 <= first_corner_q;
			tri_prev_s1 <= prev_corner_q;
			tri_cur_s1 <= in_corner;
		end
	end

	// Pick the vertex to resolve
	always_comb begin
		case (vtx_sel_s1)
			VTX_FIRST: vtx_corner = tri_first_s1;
			VTX_PREV:  vtx_corner = tri_prev_s1;
			VTX_CUR:   vtx_corner = tri_cur_s1;
			default:   vtx_corner = tri_cur_s1;
		endcase
	end

	ffan_resolve u_pos (
		.ref_val      (vtx_corner.position),
		.count        (position_cnt_q),
		.optional_ref (1'b0),
		.res          (pos_res)
	);

	ffan_resolve u_tex (
		.ref_val      (vtx_corner.texcoord),
		.count        (texcoord_cnt_q),
		.optional_ref (1'b1),
		.res          (tex_res)
	);

	ffan_resolve u_nrm (
		.ref_val      (vtx_corner.normal),
		.count        (normal_cnt_q),
		.optional_ref (1'b1),
		.res          (nrm_res)
	);

	// Output register: hold while stalled, advance when the buffer moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			position_index <= pos_res.index;
			position_ok <= pos_res.ok;
			texcoord_index <= tex_res.index;
			texcoord_present <= tex_res.present;
			texcoord_ok <= tex_res.ok;
			normal_index <= nrm_res.index;
			normal_present <= nrm_res.present;
			normal_ok <= nrm_res.ok;
			triangle_last <= (vtx_sel_s1 == VTX_CUR);
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		tri_valid_s1 |-> (vtx_sel_s1 != 2'd3))
		else $error("vertex select out of range");

	a_tri_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && emits) |=> (tri_valid_s1 && (vtx_sel_s1 == VTX_FIRST)))
		else $error("triangle buffer not loaded");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		corner_cnt_q <= CORNER_CNT_W'(MAX_CORNERS))
		else $error("corner count past limit");

	a_ok_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((!texcoord_ok || texcoord_present) && (!normal_ok || normal_present)))
		else $error("ok flag without present flag");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(tri_valid_s1 && !s1_done) |-> !(in_fire && emits))
		else $error("triangle buffer overwritten");

endmodule

// ===== tb/tb_face_fan_triangulator.sv =====
module tb_face_fan_triangulator;
	import ffan_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		ref_res_t pos;
		ref_res_t tex;
		ref_res_t nrm;
		logic     last;
	} vertex_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_REG_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [REF_W-1:0]     position_ref;
	logic [REF_W-1:0]     texcoord_ref;
	logic [REF_W-1:0]     normal_ref;
	logic                 face_end;
	logic                 out_valid;
	logic                 out_ready;
	logic [IDX_W-1:0]     position_index;
	logic                 position_ok;
	logic [IDX_W-1:0]     texcoord_index;
	logic                 texcoord_present;
	logic                 texcoord_ok;
	logic [IDX_W-1:0]     normal_index;
	logic                 normal_present;
	logic                 normal_ok;
	logic                 triangle_last;

	// Predictor state: record counts and fan state
	logic [CNT_REG_W-1:0] num_positions;
	logic [CNT_REG_W-1:0] num_texcoords;
	logic [CNT_REG_W-1:0] num_normals;
	corner_t              fan_first;
	corner_t              fan_prev;
	int                   fan_corners;
	vertex_t              pending_vertices[$];

	int  error_count;
	int  cycle_count;
	int  corners_sent;
	int  triangles_expected;
	int  vertices_checked;
	int  settings_used;
	int  stall_left;
	bit  sender_gaps;
	bit  receiver_stalls;

	face_fan_triangulator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.position_ref(position_ref),
		.texcoord_ref(texcoord_ref),
		.normal_ref(normal_ref),
		.face_end(face_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position_index(position_index),
		.position_ok(position_ok),
		.texcoord_index(texcoord_index),
		.texcoord_present(texcoord_present),
		.texcoord_ok(texcoord_ok),
		.normal_index(normal_index),
		.normal_present(normal_present),
		.normal_ok(normal_ok),
		.triangle_last(triangle_last)
	);

	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [CNT_REG_W-1:0] capped(logic [CNT_REG_W-1:0] cnt);
		return (cnt > COUNT_CAP) ? COUNT_CAP : cnt;
	endfunction

	// Turn a signed one-based or from-end reference into a record index
	function automatic ref_res_t resolve_ref(logic [REF_W-1:0] r, logic [CNT_REG_W-1:0] cnt,
			bit optional);
		ref_res_t res;
		longint   rv;
		longint   c;
		longint   idx;
		res = '0;
		res.present = 1'b1;
		rv = $signed(r);
		c = capped(cnt);
		if (optional && rv == 0) begin
			res.present = 1'b0;
			return res;
		end
		idx = (rv > 0) ? rv - 1 : c + rv;
		if (idx >= 0 && idx < c) begin
			res.index = idx[IDX_W-1:0];
			res.ok = 1'b1;
		end
		return res;
	endfunction

	function automatic vertex_t make_vertex(corner_t c, logic last);
		vertex_t v;
		v.pos = resolve_ref(c.position, num_positions, 1'b0);
		v.tex = resolve_ref(c.texcoord, num_texcoords, 1'b1);
		v.nrm = resolve_ref(c.normal, num_normals, 1'b1);
		v.last = last;
		return v;
	endfunction

	// Advance the fan on one accepted corner; queue a triangle from the third corner on
	task automatic assemble_fan(corner_t c, logic fe);
		if (fan_corners < MAX_CORNERS) begin
			if (fan_corners == 0)
				fan_first = c;
			if (fan_corners >= 2) begin
				pending_vertices.push_back(make_vertex(fan_first, 1'b0));
				pending_vertices.push_back(make_vertex(fan_prev, 1'b0));
				pending_vertices.push_back(make_vertex(c, 1'b1));
				triangles_expected++;
			end
			fan_prev = c;
			fan_corners++;
		end
		if (fe)
			fan_corners = 0;
	endtask

	task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			error_count++;
		end
	endtask

	// Compare each vertex with the oldest expected one
	always @(posedge clk) begin
		vertex_t exp_v;
		if (arst_n && out_valid && out_ready) begin
			if (pending_vertices.size() == 0) begin
				$error("vertex with no expected result: position_index %0d", position_index);
				error_count++;
			end else begin
				exp_v = pending_vertices.pop_front();
				check_field("position_index", exp_v.pos.index, position_index);
				check_field("position_ok", exp_v.pos.ok, position_ok);
				check_field("texcoord_index", exp_v.tex.index, texcoord_index);
				check_field("texcoord_present", exp_v.tex.present, texcoord_present);
				check_field("texcoord_ok", exp_v.tex.ok, texcoord_ok);
				check_field("normal_index", exp_v.nrm.index, normal_index);
				check_field("normal_present", exp_v.nrm.present, normal_present);
				check_field("normal_ok", exp_v.nrm.ok, normal_ok);
				check_field("triangle_last", exp_v.last, triangle_last);
				vertices_checked++;
			end
		end
	end

	// Stall the output in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Send one corner request and hold it until accepted
	task automatic send_corner(logic [REF_W-1:0] pos, logic [REF_W-1:0] tex,
			logic [REF_W-1:0] nrm, logic fe);
		corner_t c;
		c.position = pos;
		c.texcoord = tex;
		c.normal = nrm;
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		position_ref <= pos;
		texcoord_ref <= tex;
		normal_ref <= nrm;
		face_end <= fe;
		do @(posedge clk); while (!in_ready);
		assemble_fan(c, fe);
		corners_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Drain all expected vertices, then let the pipeline settle
	task automatic wait_idle();
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_REG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_POSITION_COUNT: num_positions = val;
			CFG_TEXCOORD_COUNT: num_texcoords = val;
			CFG_NORMAL_COUNT: num_normals = val;
			default: ;
		endcase
	endtask

	task automatic write_counts(logic [CNT_REG_W-1:0] pc, logic [CNT_REG_W-1:0] tc,
			logic [CNT_REG_W-1:0] nc);
		write_reg(CFG_POSITION_COUNT, pc);
		write_reg(CFG_TEXCOORD_COUNT, tc);
		write_reg(CFG_NORMAL_COUNT, nc);
		@(negedge clk);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// Pick a reference: mostly in range, some edges, zeros and raw noise
	function automatic logic [REF_W-1:0] pick_ref(logic [CNT_REG_W-1:0] cnt);
		longint c;
		longint v;
		c = capped(cnt);
		case ($urandom_range(0, 9))
			0: v = 0;
			1, 2: v = $urandom_range(0, (1 << REF_W) - 1);
			3: begin
				case ($urandom_range(0, 5))
					0: v = 1;
					1: v = c;
					2: v = c + 1;
					3: v = -c;
					4: v = -c - 1;
					default: v = -1;
				endcase
			end
			default: begin
				if (c == 0)
					v = $urandom_range(0, (1 << REF_W) - 1);
				else if ($urandom_range(0, 1) == 1)
					v = $urandom_range(1, int'(c));
				else
					v = -longint'($urandom_range(1, int'(c)));
			end
		endcase
		return v[REF_W-1:0];
	endfunction

	// Send whole faces of random length until the item count is reached
	task automatic random_faces(int items);
		int sent;
		int len;
		int pick;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 19);
			if (pick < 2)
				len = $urandom_range(1, 2);
			else if (pick == 2)
				len = $urandom_range(MAX_CORNERS + 1, MAX_CORNERS + 4);
			else
				len = $urandom_range(3, 8);
			for (int i = 0; i < len; i++)
				send_corner(pick_ref(num_positions), pick_ref(num_texcoords),
					pick_ref(num_normals), i == len - 1);
			sent += len;
		end
	endtask

	// Boundary indexes, absent references and field extremes in one face
	task automatic test_extreme_refs();
		write_counts(21'd10, 21'd5, 21'd7);
		send_corner(21'd1, 21'd0, 21'd0, 1'b0);
		send_corner(21'd10, 21'd5, 21'd7, 1'b0);
		send_corner(21'd11, 21'd6, -21'sd1, 1'b0);
		send_corner(21'd0, -21'sd5, -21'sd8, 1'b0);
		send_corner(21'h0FFFFF, 21'h100000, 21'h0FFFFF, 1'b1);
		drop_valid();
		wait_idle();
	endtask

	// Faces that end before their third corner emit nothing
	task automatic test_short_faces();
		send_corner(21'd3, 21'd2, 21'd1, 1'b1);
		send_corner(21'd4, 21'd0, 21'd2, 1'b0);
		send_corner(-21'sd2, 21'd1, 21'd0, 1'b1);
		drop_valid();
		wait_idle();
	endtask

	// Corners past the fan limit are dropped, face end still closes the face
	task automatic test_too_many_corners();
		for (int i = 0; i < MAX_CORNERS + 2; i++)
			send_corner(pick_ref(num_positions), pick_ref(num_texcoords),
				pick_ref(num_normals), i == MAX_CORNERS + 1);
		drop_valid();
		wait_idle();
	endtask

	// Random faces under several count settings, extremes included
	task automatic test_random_phases();
		logic [CNT_REG_W-1:0] pc;
		logic [CNT_REG_W-1:0] tc;
		logic [CNT_REG_W-1:0] nc;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin pc = '0; tc = '0; nc = '0; end
				1: begin
					pc = CNT_REG_W'(1);
					tc = CNT_REG_W'(1);
					nc = CNT_REG_W'(1);
				end
				2: begin pc = COUNT_CAP; tc = COUNT_CAP; nc = COUNT_CAP; end
				3: begin
					pc = '1;
					tc = CNT_REG_W'(COUNT_CAP - 1);
					nc = CNT_REG_W'(COUNT_CAP + 1);
				end
				4: begin
					pc = CNT_REG_W'($urandom_range(2, 64));
					tc = CNT_REG_W'($urandom_range(0, 64));
					nc = CNT_REG_W'($urandom_range(0, 64));
				end
				default: begin
					pc = CNT_REG_W'($urandom_range(0, (1 << CNT_REG_W) - 1));
					tc = CNT_REG_W'($urandom_range(0, (1 << CNT_REG_W) - 1));
					nc = CNT_REG_W'($urandom_range(0, (1 << CNT_REG_W) - 1));
				end
			endcase
			write_counts(pc, tc, nc);
			// Last phase runs at full rate
			sender_gaps = (phase < 5) && ($urandom_range(0, 3) != 0);
			receiver_stalls = (phase < 5) && ($urandom_range(0, 3) != 0);
			random_faces(80);
			drop_valid();
			wait_idle();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_POSITION_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		position_ref = '0;
		texcoord_ref = '0;
		normal_ref = '0;
		face_end = 1'b0;
		out_ready = 1'b0;
		num_positions = '0;
		num_texcoords = '0;
		num_normals = '0;
		fan_first = '0;
		fan_prev = '0;
		fan_corners = 0;
		error_count = 0;
		cycle_count = 0;
		corners_sent = 0;
		triangles_expected = 0;
		vertices_checked = 0;
		settings_used = 0;
		stall_left = 0;
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;

		// Hold reset, release between edges
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extreme_refs();
		test_short_faces();
		test_too_many_corners();
		test_random_phases();

		wait_idle();
		$display("Sent %0d corners under %0d count settings: %0d triangles expected",
			corners_sent, settings_used, triangles_expected);
		$display("Checked %0d vertices, %0d mismatches", vertices_checked, error_count);
		if (error_count == 0 && pending_vertices.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			if (pending_vertices.size() != 0)
				$error("%0d expected vertices never arrived", pending_vertices.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
